// ===== hw/rtl/pnsf_pkg.sv =====
// Package for the pink noise shaping filter: state codes, config register indexes,
// the shared multiplier's fixed widths and the fixed-point filter coefficients.
// It has no dependencies.
package pnsf_pkg;

    localparam int FRAC       = 24;
    localparam int MUL_A_W    = 32;
    localparam int CHUNK_W    = 31;
    localparam int MUL_B_W    = 25;
    localparam int CFG_DATA_W = 16;
    localparam int CLAMP_EXP  = 40;
    localparam int CLAMP_W    = CLAMP_EXP + 2;
    localparam int SECTIONS   = 7;
    localparam int NUM_POLES  = 6;

    localparam logic [2:0] TAP_IDX   = 3'd6;
    localparam logic [2:0] LAST_POLE = 3'd5;

    localparam logic CFG_NOISE_MODE  = 1'b0;
    localparam logic CFG_OUTPUT_GAIN = 1'b1;

    localparam logic [CFG_DATA_W-1:0] GAIN_RESET = 16'd32768;

    localparam logic signed [MUL_B_W-1:0] C_POLE [NUM_POLES] = '{
        25'sd16758090, 25'sd16665144, 25'sd16257122,
        25'sd14537458, 25'sd9227469, -25'sd12777528
    };
    localparam logic signed [MUL_B_W-1:0] C_WHITE [NUM_POLES] = '{
        25'sd931436, 25'sd1259565, 25'sd2581208,
        25'sd5209084, 25'sd8941454, -25'sd283501
    };
    localparam logic signed [MUL_B_W-1:0] C_DIRECT = 25'sd8995943;
    localparam logic signed [MUL_B_W-1:0] C_TAP    = 25'sd1944916;
    localparam logic signed [MUL_B_W-1:0] C_SCALE  = 25'sd1845494;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC_P,
        ST_SEC_W,
        ST_DIRECT,
        ST_TAP,
        ST_SCALE,
        ST_GAIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic gain_shift;
    } t_mac_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mac_status;

    // Index of the most significant multiplier chunk for an operand of w bits.
    function automatic int f_top_chunk(input int w);
        return (w <= MUL_A_W) ? 0 : (w - MUL_A_W + CHUNK_W - 1) / CHUNK_W;
    endfunction

endpackage

// ===== hw/rtl/pink_noise_shaping_filter_top.sv =====
// Pink noise shaping filter, top level: handshakes, config registers, filter state,
// sequencer and output register. Depends on pnsf_pkg and pnsf_mac.
//
// Each input beat is one white-noise sample; each output beat is one gain-scaled and
// saturated sample, shaped by the filter in pink mode. All products go through one shared
// 32x25 multiplier that walks its wide operand in 31-bit chunks and then hands over the
// rounded result. At the default widths a pink-mode sample takes 16 products (14
// single-chunk, 2 two-chunk), and a white-mode sample takes one two-chunk product. The
// output register lets a new sample be taken while the previous result waits. The seven
// filter registers are cleared by reset.
module pink_noise_shaping_filter_top
    import pnsf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_WIDTH    = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [CFG_DATA_W-1:0]          i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_white_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_noise_sample
);

    localparam int WQ_W    = FRAC + 1;
    localparam int WQ_SH   = WQ_W - SAMPLE_WIDTH;
    localparam int SUM_W   = ACC_WIDTH + 3;
    localparam int OPW     = (SUM_W > CLAMP_W) ? SUM_W : CLAMP_W;
    localparam int NMAX    = f_top_chunk(OPW) + 1;
    localparam int OPR_W   = CHUNK_W * (NMAX - 1) + MUL_A_W;
    localparam int IDX_W   = (NMAX > 1) ? $clog2(NMAX) : 1;
    localparam int PROD_W  = OPR_W + MUL_B_W;
    localparam int GAIN_SH = 15 + WQ_SH;

    localparam logic [IDX_W-1:0] TOP_ACC = IDX_W'(f_top_chunk(ACC_WIDTH));
    localparam logic [IDX_W-1:0] TOP_WQ  = IDX_W'(f_top_chunk(WQ_W));
    localparam logic [IDX_W-1:0] TOP_SUM = IDX_W'(f_top_chunk(SUM_W));
    localparam logic [IDX_W-1:0] TOP_CL  = IDX_W'(f_top_chunk(CLAMP_W));

    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] OUT_HI = PROD_W'(OUT_MAX);
    localparam logic signed [PROD_W-1:0] OUT_LO = PROD_W'(OUT_MIN);
    localparam logic signed [PROD_W-1:0] CL_HI  = PROD_W'(1) <<< CLAMP_EXP;
    localparam logic signed [PROD_W-1:0] CL_LO  = -CL_HI;

    t_state                          r_state;
    t_state                          n_state;
    logic                            r_noise_mode;
    logic [CFG_DATA_W-1:0]           r_output_gain;
    logic signed [ACC_WIDTH-1:0]     r_sec_q [SECTIONS];
    logic [2:0]                      r_sec;
    logic signed [WQ_W-1:0]          r_wq;
    logic signed [ACC_WIDTH:0]       r_part;
    logic signed [SUM_W-1:0]         r_sum;
    logic signed [CLAMP_W-1:0]       r_scaled;
    logic                            r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0]  r_out;

    t_mac_req                        mac_req;
    t_mac_status                     mac_st;
    logic [IDX_W-1:0]                mac_top;
    logic signed [OPR_W-1:0]         mac_a;
    logic signed [MUL_B_W-1:0]       mac_b;
    logic signed [PROD_W-1:0]        res;

    logic                            in_acc;
    logic                            out_free;
    logic                            emit;
    logic                            mul_state;
    logic signed [WQ_W-1:0]          wq_in;
    logic signed [ACC_WIDTH:0]       res_acc;
    logic signed [ACC_WIDTH:0]       sec_sum;
    logic signed [ACC_WIDTH-1:0]     sec_sat;
    logic signed [ACC_WIDTH-1:0]     tap_sat;
    logic signed [CLAMP_W-1:0]       clamp_val;
    logic signed [SAMPLE_WIDTH-1:0]  out_val;

    pnsf_mac #(
        .P_OPR_W      (OPR_W),
        .P_IDX_W      (IDX_W),
        .P_PROD_W     (PROD_W),
        .P_GAIN_SHIFT (GAIN_SH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mac_req),
        .i_top    (mac_top),
        .i_a      (mac_a),
        .i_b      (mac_b),
        .o_status (mac_st),
        .o_result (res)
    );

    assign o_in_ready     = (r_state == ST_IDLE);
    assign in_acc         = i_in_valid && o_in_ready;
    assign out_free       = !r_out_valid || i_out_ready;
    assign emit           = (r_state == ST_EMIT) && out_free;
    assign o_out_valid    = r_out_valid;
    assign o_noise_sample = r_out;
    assign wq_in          = $signed({i_white_sample, {WQ_SH{1'b0}}});

    always_comb begin
        res_acc = $signed(res[ACC_WIDTH:0]);
        sec_sum = r_part + res_acc;
        if (sec_sum[ACC_WIDTH] != sec_sum[ACC_WIDTH-1]) begin
            sec_sat = sec_sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end else begin
            sec_sat = sec_sum[ACC_WIDTH-1:0];
        end
        if (res_acc[ACC_WIDTH] != res_acc[ACC_WIDTH-1]) begin
            tap_sat = res_acc[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end else begin
            tap_sat = res_acc[ACC_WIDTH-1:0];
        end
        if (res > CL_HI) begin
            clamp_val = CLAMP_W'(CL_HI);
        end else if (res < CL_LO) begin
            clamp_val = CLAMP_W'(CL_LO);
        end else begin
            clamp_val = res[CLAMP_W-1:0];
        end
        if (res > OUT_HI) begin
            out_val = OUT_MAX;
        end else if (res < OUT_LO) begin
            out_val = OUT_MIN;
        end else begin
            out_val = res[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = r_noise_mode ? ST_SEC_P : ST_GAIN;
                end
            end
            ST_SEC_P: begin
                if (mac_st.done) begin
                    n_state = ST_SEC_W;
                end
            end
            ST_SEC_W: begin
                if (mac_st.done) begin
                    n_state = (r_sec == LAST_POLE) ? ST_DIRECT : ST_SEC_P;
                end
            end
            ST_DIRECT: begin
                if (mac_st.done) begin
                    n_state = ST_TAP;
                end
            end
            ST_TAP: begin
                if (mac_st.done) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (mac_st.done) begin
                    n_state = ST_GAIN;
                end
            end
            ST_GAIN: begin
                if (mac_st.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        mul_state          = 1'b0;
        mac_req.gain_shift = 1'b0;
        mac_top            = '0;
        mac_a              = '0;
        mac_b              = '0;
        unique case (r_state)
            ST_SEC_P: begin
                mul_state = 1'b1;
                mac_top   = TOP_ACC;
                mac_a     = OPR_W'(r_sec_q[r_sec]);
                mac_b     = C_POLE[r_sec];
            end
            ST_SEC_W: begin
                mul_state = 1'b1;
                mac_top   = TOP_WQ;
                mac_a     = OPR_W'(r_wq);
                mac_b     = C_WHITE[r_sec];
            end
            ST_DIRECT: begin
                mul_state = 1'b1;
                mac_top   = TOP_WQ;
                mac_a     = OPR_W'(r_wq);
                mac_b     = C_DIRECT;
            end
            ST_TAP: begin
                mul_state = 1'b1;
                mac_top   = TOP_WQ;
                mac_a     = OPR_W'(r_wq);
                mac_b     = C_TAP;
            end
            ST_SCALE: begin
                mul_state = 1'b1;
                mac_top   = TOP_SUM;
                mac_a     = OPR_W'(r_sum);
                mac_b     = C_SCALE;
            end
            ST_GAIN: begin
                mul_state          = 1'b1;
                mac_req.gain_shift = 1'b1;
                mac_top            = TOP_CL;
                mac_a              = OPR_W'(r_scaled);
                mac_b              = $signed({{(MUL_B_W-CFG_DATA_W){1'b0}}, r_output_gain});
            end
            default: begin
                mul_state = 1'b0;
            end
        endcase
        mac_req.start = mul_state && !mac_st.busy && !mac_st.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_noise_mode  <= 1'b0;
            r_output_gain <= GAIN_RESET;
            r_out_valid   <= 1'b0;
            r_sec         <= '0;
            for (int k = 0; k < SECTIONS; k++) begin
                r_sec_q[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_NOISE_MODE:  r_noise_mode  <= i_cfg_data[0];
                    CFG_OUTPUT_GAIN: r_output_gain <= i_cfg_data;
                    default:         r_noise_mode  <= r_noise_mode;
                endcase
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_sec <= '0;
            end else if ((r_state == ST_SEC_W) && mac_st.done) begin
                r_sec <= (r_sec == LAST_POLE) ? 3'd0 : r_sec + 3'd1;
            end
            if ((r_state == ST_SEC_W) && mac_st.done) begin
                r_sec_q[r_sec] <= sec_sat;
            end
            if ((r_state == ST_TAP) && mac_st.done) begin
                r_sec_q[TAP_IDX] <= tap_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_wq     <= wq_in;
            r_scaled <= CLAMP_W'(wq_in);
            r_sum    <= '0;
        end
        if (mac_st.done) begin
            unique case (r_state)
                ST_SEC_P:  r_part   <= res_acc;
                ST_SEC_W:  r_sum    <= r_sum + SUM_W'(sec_sat);
                ST_DIRECT: r_sum    <= r_sum + SUM_W'(r_sec_q[TAP_IDX])
                                     + $signed(res[SUM_W-1:0]);
                ST_SCALE:  r_scaled <= clamp_val;
                default:   r_part   <= r_part;
            endcase
        end
        if (emit) begin
            r_out <= out_val;
        end
    end

    a_ready_mac_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!mac_st.busy && !mac_st.done))
        else $error("Input ready while the multiplier still holds work.");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != ST_IDLE))
        else $error("Accepted beat did not start the sequencer.");

    a_gain_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_GAIN) && mac_st.done) |=> (r_state == ST_EMIT))
        else $error("Gain product was not handed to the output stage.");

    a_emit_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && !r_out_valid) |=> o_out_valid)
        else $error("Free output register was not loaded.");

endmodule

// ===== hw/rtl/pnsf_mac.sv =====
// Shared multiply unit of the pink noise filter: a 32x25 signed multiplier walks a wide
// operand one chunk per cycle, most significant first, then rounds half up.
// Depends on pnsf_pkg.
module pnsf_mac
    import pnsf_pkg::*;
#(
    parameter int P_OPR_W      = 63,
    parameter int P_IDX_W      = 1,
    parameter int P_PROD_W     = 88,
    parameter int P_GAIN_SHIFT = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_req                   i_req,
    input  logic [P_IDX_W-1:0]         i_top,
    input  logic signed [P_OPR_W-1:0]  i_a,
    input  logic signed [MUL_B_W-1:0]  i_b,
    output t_mac_status                o_status,
    output logic signed [P_PROD_W-1:0] o_result
);

    localparam logic signed [P_PROD_W-1:0] HALF_COEF = P_PROD_W'(1) <<< (FRAC - 1);
    localparam logic signed [P_PROD_W-1:0] HALF_GAIN = P_PROD_W'(1) <<< (P_GAIN_SHIFT - 1);

    logic                              r_busy;
    logic                              r_done;
    logic                              r_gsh;
    logic [P_IDX_W-1:0]                r_idx;
    logic signed [P_PROD_W-1:0]        r_acc;

    logic                              active;
    logic                              first;
    logic                              last;
    logic                              gsh;
    logic [P_IDX_W-1:0]                idx;
    logic signed [MUL_A_W-1:0]         chunk;
    logic signed [MUL_A_W+MUL_B_W-1:0] prod;
    logic signed [P_PROD_W-1:0]        n_acc;

    always_comb begin
        first  = !r_busy;
        active = r_busy || i_req.start;
        idx    = r_busy ? r_idx : i_top;
        last   = (idx == '0);
        gsh    = first ? i_req.gain_shift : r_gsh;
        if (first) begin
            chunk = $signed(i_a[idx*CHUNK_W +: MUL_A_W]);
        end else begin
            chunk = $signed({1'b0, i_a[idx*CHUNK_W +: CHUNK_W]});
        end
        prod  = chunk * i_b;
        n_acc = (first ? '0 : (r_acc <<< CHUNK_W)) + P_PROD_W'(prod)
              + (last ? (gsh ? HALF_GAIN : HALF_COEF) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= active && last;
            if (active) begin
                r_busy <= !last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (active) begin
            r_acc <= n_acc;
            r_idx <= idx - P_IDX_W'(1);
            if (first) begin
                r_gsh <= i_req.gain_shift;
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_result      = r_gsh ? (r_acc >>> P_GAIN_SHIFT) : (r_acc >>> FRAC);

endmodule

// ===== tb/pink_noise_checker.sv =====
// Scoreboard for the pink noise shaping filter: watches the config port and both
// stream channels, predicts every output beat and compares it. Depends on pnsf_pkg.
`timescale 1ns / 1ps
module pink_noise_checker
    import pnsf_pkg::*;
#(
    parameter int SW    = 16,
    parameter int ACC_W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic signed [SW-1:0] i_white_sample,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic signed [SW-1:0] i_noise_sample,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int     FB       = 24;
    localparam int     IN_SHIFT = FB + 1 - SW;
    localparam int     OUT_SH   = 15 + IN_SHIFT;
    localparam longint HALF_FB  = longint'(1) <<< (FB - 1);
    localparam longint PINK_CAP = longint'(1) <<< 40;

    localparam longint POLE_K [6] = '{
        16758090, 16665144, 16257122, 14537458, 9227469, -12777528
    };
    localparam longint DRIVE_K [6] = '{
        931436, 1259565, 2581208, 5209084, 8941454, -283501
    };
    localparam longint DIRECT_K = 8995943;
    localparam longint DELAY_K  = 1944916;
    localparam longint SCALE_K  = 1845494;

    longint                 sect [7];
    logic                   pink_on;
    longint                 gain_val;
    logic signed [SW-1:0]   expected_noise_q [$];
    int                     fail_total = 0;

    function automatic longint f_qmul(input longint a, input longint k);
        return (a * k + HALF_FB) >>> FB;
    endfunction

    function automatic longint f_clip(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic signed [SW-1:0] f_predict_noise(input logic signed [SW-1:0] white);
        longint w;
        longint wq;
        longint acc;
        longint scaled;
        longint r;
        w = longint'(white);
        if (!pink_on) begin
            r = (w * gain_val + (longint'(1) <<< 14)) >>> 15;
        end else begin
            wq = w <<< IN_SHIFT;
            for (int i = 0; i < 6; i++) begin
                sect[i] = f_clip(f_qmul(sect[i], POLE_K[i]) + f_qmul(wq, DRIVE_K[i]), ACC_W);
            end
            acc = f_qmul(wq, DIRECT_K);
            for (int i = 0; i < 7; i++) begin
                acc += sect[i];
            end
            sect[6] = f_clip(f_qmul(wq, DELAY_K), ACC_W);
            scaled = f_qmul(acc, SCALE_K);
            if (scaled > PINK_CAP) scaled = PINK_CAP;
            if (scaled < -PINK_CAP) scaled = -PINK_CAP;
            r = (scaled * gain_val + (longint'(1) <<< (OUT_SH - 1))) >>> OUT_SH;
        end
        r = f_clip(r, SW);
        return r[SW-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        fail_total++;
        $display("[%0t] noise checker: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        logic signed [SW-1:0] want;
        if (!i_rst_n) begin
            foreach (sect[i]) sect[i] = 0;
            pink_on = 1'b0;
            gain_val = longint'(GAIN_RESET);
            expected_noise_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_OUTPUT_GAIN) gain_val = longint'(i_cfg_data);
                else if (i_cfg_index == CFG_NOISE_MODE) pink_on = i_cfg_data[0];
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_noise_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected output beat %0d", i_noise_sample));
                end else begin
                    want = expected_noise_q.pop_front();
                    if (i_noise_sample !== want) begin
                        report_mismatch($sformatf("noise_sample got %0d expected %0d",
                                                  i_noise_sample, want));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_noise_q.insert(expected_noise_q.size(),
                                        f_predict_noise(i_white_sample));
            end
        end
        o_pending    <= expected_noise_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== tb/pink_noise_shaping_filter_top_tb.sv =====
// Top-level testbench for the pink noise shaping filter: clock, reset, config writes,
// input stimulus with random idling and the verdict. Depends on pnsf_pkg,
// pink_noise_shaping_filter_top and pink_noise_checker.
`timescale 1ns / 1ps
module pink_noise_shaping_filter_top_tb;
    import pnsf_pkg::*;

    localparam int SW = 16;
    localparam logic [CFG_DATA_W-1:0] MODE_WHITE = 16'd0;
    localparam logic [CFG_DATA_W-1:0] MODE_PINK  = 16'd1;
    localparam logic [CFG_DATA_W-1:0] GAIN_MAX   = 16'hFFFF;
    localparam logic [CFG_DATA_W-1:0] GAIN_ZERO  = 16'd0;
    localparam logic signed [SW-1:0]  S_MAX      = 16'sh7FFF;
    localparam logic signed [SW-1:0]  S_MIN      = 16'sh8000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic                   cfg_index = CFG_NOISE_MODE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic signed [SW-1:0]   white_sample = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic signed [SW-1:0]   noise_sample;
    int                     fail_count;
    int                     pending;
    int                     tx_idle_pct = 0;
    int                     rx_idle_pct = 0;

    pink_noise_shaping_filter_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_white_sample (white_sample),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_noise_sample (noise_sample)
    );

    pink_noise_checker #(.SW(SW), .ACC_W(32)) noise_chk (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_white_sample (white_sample),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_noise_sample (noise_sample),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_sample(input logic signed [SW-1:0] v);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        white_sample <= v;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] mode_val,
                              input logic [CFG_DATA_W-1:0] gain_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NOISE_MODE;
        cfg_data  <= mode_val;
        @(posedge clk);
        cfg_index <= CFG_OUTPUT_GAIN;
        cfg_data  <= gain_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic signed [SW-1:0]  v;
        logic signed [SW-1:0]  held;
        logic [CFG_DATA_W-1:0] mode_val;
        logic [CFG_DATA_W-1:0] gain_val;
        int                    style;

        tx_idle_pct = 36;
        rx_idle_pct = 85;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        drain_results();

        // Reset configuration: white mode at unity gain.
        send_sample('0);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        drain_results();
        set_config(MODE_WHITE, GAIN_MAX);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(16'sh4000);
        drain_results();
        // Only bit 0 of the mode write counts, so this stays in white mode.
        set_config(16'hFFFE, GAIN_ZERO);
        send_sample(S_MIN);
        drain_results();
        set_config(16'h0003, GAIN_RESET);
        send_sample('0);
        repeat (3) send_sample(S_MAX);
        repeat (3) send_sample(S_MIN);
        send_sample(16'sd1);
        drain_results();
        set_config(MODE_PINK, GAIN_MAX);
        repeat (5) send_sample(S_MAX);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 85 : 0;
            rx_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 36 : 0;
            for (int seg = 0; seg < 8; seg++) begin
                drain_results();
                mode_val = 16'($urandom);
                mode_val[0] = ($urandom_range(99) < 70);
                case ($urandom_range(4))
                    0: gain_val = GAIN_ZERO;
                    1: gain_val = GAIN_MAX;
                    2: gain_val = GAIN_RESET;
                    default: gain_val = 16'($urandom_range(65535));
                endcase
                set_config(mode_val, gain_val);
                style = $urandom_range(3);
                held = S_MAX;
                for (int n = 0; n < 60; n++) begin
                    case (style)
                        0: v = 16'($urandom);
                        1: begin
                            if ($urandom_range(9) == 0) begin
                                case ($urandom_range(2))
                                    0: held = S_MAX;
                                    1: held = S_MIN;
                                    default: held = 16'($urandom);
                                endcase
                            end
                            v = held;
                        end
                        2: v = 16'($urandom_range(64)) - 16'd32;
                        default: begin
                            if ($urandom_range(1) == 0) v = $urandom_range(1) ? S_MAX : S_MIN;
                            else v = 16'($urandom);
                        end
                    endcase
                    send_sample(v);
                end
            end
        end

        drain_results();
        repeat (64) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/pnsf_pkg.sv
hw/rtl/pnsf_mac.sv
hw/rtl/pink_noise_shaping_filter_top.sv
tb/pink_noise_checker.sv
tb/pink_noise_shaping_filter_top_tb.sv
